[rtl/kvt_pkg.sv]
`timescale 1ns / 1ps
// Types, codes and per-byte tokenizer step for the key/value text tokenizer.
// Used by kvt_csr, kvt_lexer, kvt_out_queue and the top level; depends on nothing.
package kvt_pkg;

   localparam int unsigned MAX_EVENTS = 4;
   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [1:0] REG_DEPTH_LIMIT = 2'd0;
   localparam logic [1:0] REG_TOKEN_LIMIT = 2'd1;
   localparam logic [1:0] REG_ENTRY_LIMIT = 2'd2;
   localparam logic [1:0] REG_INPUT_LIMIT = 2'd3;

   localparam logic [5:0]  DEPTH_LIMIT_RESET = 6'd16;
   localparam logic [12:0] TOKEN_LIMIT_RESET = 13'd4096;
   localparam logic [16:0] ENTRY_LIMIT_RESET = 17'd100000;
   localparam logic [20:0] INPUT_LIMIT_RESET = 21'd1048576;

   localparam logic [2:0] MODE_SPACE   = 3'd0;
   localparam logic [2:0] MODE_SLASH   = 3'd1;
   localparam logic [2:0] MODE_COMMENT = 3'd2;
   localparam logic [2:0] MODE_BARE    = 3'd3;
   localparam logic [2:0] MODE_QUOTED  = 3'd4;
   localparam logic [2:0] MODE_ESCAPE  = 3'd5;

   localparam logic [2:0] EV_KEY_CHAR   = 3'd0;
   localparam logic [2:0] EV_VALUE_CHAR = 3'd1;
   localparam logic [2:0] EV_KEY_END    = 3'd2;
   localparam logic [2:0] EV_VALUE_END  = 3'd3;
   localparam logic [2:0] EV_OPEN       = 3'd4;
   localparam logic [2:0] EV_CLOSE      = 3'd5;
   localparam logic [2:0] EV_DOC_OK     = 3'd6;
   localparam logic [2:0] EV_ERROR      = 3'd7;

   localparam logic [3:0] ERR_TOO_DEEP         = 4'd0;
   localparam logic [3:0] ERR_OPEN_OBJECT      = 4'd1;
   localparam logic [3:0] ERR_STRAY_CLOSE      = 4'd2;
   localparam logic [3:0] ERR_NO_KEY           = 4'd3;
   localparam logic [3:0] ERR_NO_VALUE         = 4'd4;
   localparam logic [3:0] ERR_TOO_MANY_ENTRIES = 4'd5;
   localparam logic [3:0] ERR_CTRL_BARE        = 4'd6;
   localparam logic [3:0] ERR_CTRL_QUOTED      = 4'd7;
   localparam logic [3:0] ERR_TOO_LONG         = 4'd8;
   localparam logic [3:0] ERR_OPEN_ESCAPE      = 4'd9;
   localparam logic [3:0] ERR_OPEN_QUOTE       = 4'd10;
   localparam logic [3:0] ERR_TOO_LARGE        = 4'd11;
   localparam logic [3:0] ERR_NONE             = 4'd12;

   localparam logic [7:0] CH_BOM_0    = 8'hEF;
   localparam logic [7:0] CH_BOM_1    = 8'hBB;
   localparam logic [7:0] CH_BOM_2    = 8'hBF;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_N        = 8'h6E;
   localparam logic [7:0] CH_R        = 8'h72;
   localparam logic [7:0] CH_T        = 8'h74;

   typedef struct packed {
      logic [5:0]  depth_limit;
      logic [12:0] token_limit;
      logic [16:0] entry_limit;
      logic [20:0] input_limit;
   } limit_type;

   typedef struct packed {
      logic [2:0]  lex_mode;
      logic        expect_value;
      logic [5:0]  depth_count;
      logic [13:0] token_length;
      logic [16:0] entries_seen;
      logic [20:0] bytes_seen;
      logic [1:0]  bom_progress;
      logic        error_latched;
   } doc_type;

   localparam doc_type DOC_CLEAR = '{
      lex_mode: MODE_SPACE, expect_value: 1'b0, depth_count: 6'd0, token_length: 14'd0,
      entries_seen: 17'd0, bytes_seen: 21'd0, bom_progress: 2'd0, error_latched: 1'b0};

   typedef struct packed {
      logic [2:0] event_kind;
      logic [7:0] char_out;
      logic [5:0] nest_depth;
      logic [3:0] error_code;
   } event_type;

   typedef struct packed {
      event_type [MAX_EVENTS-1:0] ev;
      logic [2:0]                 count;
   } group_type;

   typedef struct packed {
      doc_type   doc;
      group_type grp;
   } work_type;

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   function automatic work_type w_emit(work_type w, logic [2:0] kind, logic [7:0] ch,
                                       logic [3:0] code);
      if (w.grp.count < 3'(MAX_EVENTS)) begin
         w.grp.ev[w.grp.count[1:0]] = '{event_kind: kind, char_out: ch,
                                        nest_depth: w.doc.depth_count, error_code: code};
         w.grp.count = w.grp.count + 3'd1;
      end
      return w;
   endfunction

   function automatic work_type w_fail(work_type w, logic [3:0] code);
      w = w_emit(w, EV_ERROR, 8'h00, code);
      w.doc.error_latched = 1'b1;
      return w;
   endfunction

   function automatic work_type w_char(work_type w, logic [7:0] c);
      return w_emit(w, w.doc.expect_value ? EV_VALUE_CHAR : EV_KEY_CHAR, c, ERR_NONE);
   endfunction

   function automatic work_type w_end_token(work_type w);
      w = w_emit(w, w.doc.expect_value ? EV_VALUE_END : EV_KEY_END, 8'h00, ERR_NONE);
      w.doc.expect_value = ~w.doc.expect_value;
      w.doc.lex_mode = MODE_SPACE;
      return w;
   endfunction

   // count an entry as its value starts
   function automatic work_type w_value_gate(work_type w, limit_type lim);
      if (w.doc.expect_value) begin
         if (w.doc.entries_seen >= lim.entry_limit) begin
            w = w_fail(w, ERR_TOO_MANY_ENTRIES);
         end else begin
            w.doc.entries_seen = w.doc.entries_seen + 17'd1;
         end
      end
      return w;
   endfunction

   function automatic work_type w_bare_start(work_type w, logic [7:0] c, limit_type lim);
      if (c < CH_SPACE) begin
         w = w_fail(w, ERR_CTRL_BARE);
      end else begin
         w.doc.token_length = 14'd1;
         if (lim.token_limit == 13'd0) begin
            w = w_fail(w, ERR_TOO_LONG);
         end else begin
            w = w_char(w, c);
            w.doc.lex_mode = MODE_BARE;
         end
      end
      return w;
   endfunction

   function automatic work_type w_space_byte(work_type w, logic [7:0] c, limit_type lim);
      priority if (is_blank(c)) begin
      end else if (c == CH_SLASH) begin
         w.doc.lex_mode = MODE_SLASH;
      end else if (c == CH_RBRACE) begin
         priority if (w.doc.expect_value) begin
            w = w_fail(w, ERR_NO_VALUE);
         end else if (w.doc.depth_count == 6'd0) begin
            w = w_fail(w, ERR_STRAY_CLOSE);
         end else begin
            w.doc.depth_count = w.doc.depth_count - 6'd1;
            w = w_emit(w, EV_CLOSE, 8'h00, ERR_NONE);
         end
      end else if (c == CH_LBRACE) begin
         if (!w.doc.expect_value) begin
            w = w_fail(w, ERR_NO_KEY);
         end else begin
            w = w_value_gate(w, lim);
            if (!w.doc.error_latched) begin
               if (({1'b0, w.doc.depth_count} + 7'd1) > {1'b0, lim.depth_limit}) begin
                  w = w_fail(w, ERR_TOO_DEEP);
               end else begin
                  w.doc.depth_count = w.doc.depth_count + 6'd1;
                  w.doc.expect_value = 1'b0;
                  w = w_emit(w, EV_OPEN, 8'h00, ERR_NONE);
               end
            end
         end
      end else begin
         w = w_value_gate(w, lim);
         if (!w.doc.error_latched) begin
            if (c == CH_QUOTE) begin
               w.doc.token_length = 14'd0;
               w.doc.lex_mode = MODE_QUOTED;
            end else begin
               w = w_bare_start(w, c, lim);
            end
         end
      end
      return w;
   endfunction

   function automatic work_type w_bare_byte(work_type w, logic [7:0] c, limit_type lim);
      logic [13:0] len;
      len = w.doc.token_length + 14'd1;
      priority if (is_blank(c)) begin
         w = w_end_token(w);
      end else if ((c == CH_LBRACE) || (c == CH_RBRACE)) begin
         w = w_end_token(w);
         w = w_space_byte(w, c, lim);
      end else if (c < CH_SPACE) begin
         w = w_fail(w, ERR_CTRL_BARE);
      end else if (len > {1'b0, lim.token_limit}) begin
         w = w_fail(w, ERR_TOO_LONG);
      end else begin
         w.doc.token_length = len;
         w = w_char(w, c);
      end
      return w;
   endfunction

   function automatic work_type w_quoted_byte(work_type w, logic [7:0] c, limit_type lim);
      logic [13:0] len;
      len = w.doc.token_length + 14'd1;
      priority if (c == CH_QUOTE) begin
         w = w_end_token(w);
      end else if ((c < CH_SPACE) && (c != CH_TAB)) begin
         w = w_fail(w, ERR_CTRL_QUOTED);
      end else if (c == CH_BSLASH) begin
         w.doc.token_length = len;
         w.doc.lex_mode = MODE_ESCAPE;
      end else if (len > {1'b0, lim.token_limit}) begin
         w = w_fail(w, ERR_TOO_LONG);
      end else begin
         w.doc.token_length = len;
         w = w_char(w, c);
      end
      return w;
   endfunction

   function automatic work_type w_escape_byte(work_type w, logic [7:0] e, limit_type lim);
      logic [13:0] len;
      len = w.doc.token_length + 14'd1;
      w.doc.token_length = len;
      w.doc.lex_mode = MODE_QUOTED;
      priority if (len > {1'b0, lim.token_limit}) begin
         w = w_fail(w, ERR_TOO_LONG);
      end else if ((e == CH_QUOTE) || (e == CH_BSLASH)) begin
         w = w_char(w, e);
      end else if (e == CH_N) begin
         w = w_char(w, CH_LF);
      end else if (e == CH_R) begin
         w = w_char(w, CH_CR);
      end else if (e == CH_T) begin
         w = w_char(w, CH_TAB);
      end else begin
         w = w_char(w, CH_BSLASH);
         w = w_char(w, e);
      end
      return w;
   endfunction

   function automatic work_type w_slash_byte(work_type w, logic [7:0] c, limit_type lim);
      if (c == CH_SLASH) begin
         w.doc.lex_mode = MODE_COMMENT;
      end else begin
         w.doc.lex_mode = MODE_SPACE;
         w = w_value_gate(w, lim);
         if (!w.doc.error_latched) begin
            w = w_bare_start(w, CH_SLASH, lim);
            if (!w.doc.error_latched) begin
               w = w_bare_byte(w, c, lim);
            end
         end
      end
      return w;
   endfunction

   function automatic work_type w_feed(work_type w, logic [7:0] c, limit_type lim);
      if (!w.doc.error_latched) begin
         unique case (w.doc.lex_mode)
            MODE_SPACE: w = w_space_byte(w, c, lim);
            MODE_SLASH: w = w_slash_byte(w, c, lim);
            MODE_COMMENT: begin
               if (c == CH_LF) begin
                  w.doc.lex_mode = MODE_SPACE;
               end
            end
            MODE_BARE: w = w_bare_byte(w, c, lim);
            MODE_QUOTED: w = w_quoted_byte(w, c, lim);
            default: w = w_escape_byte(w, c, lim);
         endcase
      end
      return w;
   endfunction

   // held mark bytes only exist at document start: replay them as the first key
   function automatic work_type w_replay(work_type w, limit_type lim);
      if ((w.doc.bom_progress == 2'd1) || (w.doc.bom_progress == 2'd2)) begin
         w.doc.token_length = 14'd1;
         if (lim.token_limit == 13'd0) begin
            w = w_fail(w, ERR_TOO_LONG);
         end else begin
            w = w_char(w, CH_BOM_0);
            w.doc.lex_mode = MODE_BARE;
            if (w.doc.bom_progress == 2'd2) begin
               w.doc.token_length = 14'd2;
               if (lim.token_limit < 13'd2) begin
                  w = w_fail(w, ERR_TOO_LONG);
               end else begin
                  w = w_char(w, CH_BOM_1);
               end
            end
         end
      end
      w.doc.bom_progress = 2'd3;
      return w;
   endfunction

   function automatic work_type w_finish(work_type w, limit_type lim);
      if (!w.doc.error_latched) begin
         w = w_replay(w, lim);
      end
      if (!w.doc.error_latched && (w.doc.lex_mode == MODE_SLASH)) begin
         w.doc.lex_mode = MODE_SPACE;
         w = w_value_gate(w, lim);
         if (!w.doc.error_latched) begin
            w = w_bare_start(w, CH_SLASH, lim);
         end
      end
      if (!w.doc.error_latched) begin
         priority if (w.doc.lex_mode == MODE_QUOTED) begin
            w = w_fail(w, ERR_OPEN_QUOTE);
         end else if (w.doc.lex_mode == MODE_ESCAPE) begin
            w = w_fail(w, ERR_OPEN_ESCAPE);
         end else begin
            if (w.doc.lex_mode == MODE_BARE) begin
               w = w_end_token(w);
            end
            priority if (w.doc.expect_value) begin
               w = w_fail(w, ERR_NO_VALUE);
            end else if (w.doc.depth_count != 6'd0) begin
               w = w_fail(w, ERR_OPEN_OBJECT);
            end else begin
               w = w_emit(w, EV_DOC_OK, 8'h00, ERR_NONE);
            end
         end
      end
      w.doc = DOC_CLEAR;
      return w;
   endfunction

   function automatic work_type kvt_step(doc_type doc, logic [7:0] c, logic eod,
                                         limit_type lim);
      work_type w;
      w.doc = doc;
      w.grp = '0;
      if (eod) begin
         w = w_finish(w, lim);
      end else if (!w.doc.error_latched) begin
         if (w.doc.bytes_seen >= lim.input_limit) begin
            w = w_fail(w, ERR_TOO_LARGE);
         end else begin
            w.doc.bytes_seen = w.doc.bytes_seen + 21'd1;
            unique case (w.doc.bom_progress)
               2'd0: begin
                  if (c == CH_BOM_0) begin
                     w.doc.bom_progress = 2'd1;
                  end else begin
                     w.doc.bom_progress = 2'd3;
                     w = w_feed(w, c, lim);
                  end
               end
               2'd1: begin
                  if (c == CH_BOM_1) begin
                     w.doc.bom_progress = 2'd2;
                  end else begin
                     w = w_replay(w, lim);
                     w = w_feed(w, c, lim);
                  end
               end
               2'd2: begin
                  if (c == CH_BOM_2) begin
                     w.doc.bom_progress = 2'd3;
                  end else begin
                     w = w_replay(w, lim);
                     w = w_feed(w, c, lim);
                  end
               end
               default: w = w_feed(w, c, lim);
            endcase
         end
      end
      return w;
   endfunction

endpackage

[rtl/kvt_req_if.sv]
`timescale 1ns / 1ps
// Input channel: one document byte or end mark per word, valid/ready handshake.
// Standalone; no package needed.
interface kvt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_document;

   modport source (output valid, output data_byte, output end_of_document, input ready);
   modport sink (input valid, input data_byte, input end_of_document, output ready);
endinterface

[rtl/kvt_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel: one tokenizer event per word, valid/ready handshake.
// Standalone; no package needed.
interface kvt_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_kind;
   logic [7:0] char_out;
   logic [5:0] nest_depth;
   logic [3:0] error_code;
   logic       last_of_run;

   modport source (output valid, output event_kind, output char_out, output nest_depth,
                   output error_code, output last_of_run, input ready);
   modport sink (input valid, input event_kind, input char_out, input nest_depth,
                 input error_code, input last_of_run, output ready);
endinterface

[rtl/kvt_csr.sv]
`timescale 1ns / 1ps
// APB register file holding the four document limits.
// Depends on kvt_pkg for the limit struct, register indexes and reset values.
module kvt_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [kvt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output kvt_pkg::limit_type             limits
);

   kvt_pkg::limit_type limits_ff;
   kvt_pkg::limit_type limits_in;
   logic [1:0]         reg_index;

   assign reg_index = paddr[3:2];
   assign pready    = 1'b1;
   assign limits    = limits_ff;

   always_comb begin
      limits_in = limits_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_index)
            kvt_pkg::REG_DEPTH_LIMIT: limits_in.depth_limit = pwdata[5:0];
            kvt_pkg::REG_TOKEN_LIMIT: limits_in.token_limit = pwdata[12:0];
            kvt_pkg::REG_ENTRY_LIMIT: limits_in.entry_limit = pwdata[16:0];
            kvt_pkg::REG_INPUT_LIMIT: limits_in.input_limit = pwdata[20:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         kvt_pkg::REG_DEPTH_LIMIT: prdata = 32'(limits_ff.depth_limit);
         kvt_pkg::REG_TOKEN_LIMIT: prdata = 32'(limits_ff.token_limit);
         kvt_pkg::REG_ENTRY_LIMIT: prdata = 32'(limits_ff.entry_limit);
         kvt_pkg::REG_INPUT_LIMIT: prdata = 32'(limits_ff.input_limit);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.depth_limit <= kvt_pkg::DEPTH_LIMIT_RESET;
         limits_ff.token_limit <= kvt_pkg::TOKEN_LIMIT_RESET;
         limits_ff.entry_limit <= kvt_pkg::ENTRY_LIMIT_RESET;
         limits_ff.input_limit <= kvt_pkg::INPUT_LIMIT_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

endmodule

[rtl/kvt_lexer.sv]
`timescale 1ns / 1ps
// Input register, document state and the one-pass byte step that builds an event group.
// Depends on kvt_pkg (step function, types) and kvt_req_if.
module kvt_lexer #(
   parameter int unsigned DEPTH_LIMIT_MAX = 63,
   parameter int unsigned TOKEN_LIMIT_MAX = 8191,
   parameter int unsigned ENTRY_LIMIT_MAX = 131071
) (
   input  logic                clock,
   input  logic                reset,
   kvt_req_if.sink             req,
   input  kvt_pkg::limit_type  limits,
   input  logic                sink_free,
   output kvt_pkg::group_type  group,
   output logic                group_load
);

   logic               hold_valid_ff, hold_valid_in;
   logic [7:0]         hold_byte_ff, hold_byte_in;
   logic               hold_eod_ff, hold_eod_in;
   kvt_pkg::doc_type   doc_ff, doc_in;
   kvt_pkg::limit_type lim;
   kvt_pkg::work_type  step;
   logic               take_req;

   always_comb begin
      lim = limits;
      if (32'(limits.depth_limit) > DEPTH_LIMIT_MAX) begin
         lim.depth_limit = 6'(DEPTH_LIMIT_MAX);
      end
      if (32'(limits.token_limit) > TOKEN_LIMIT_MAX) begin
         lim.token_limit = 13'(TOKEN_LIMIT_MAX);
      end
      if (32'(limits.entry_limit) > ENTRY_LIMIT_MAX) begin
         lim.entry_limit = 17'(ENTRY_LIMIT_MAX);
      end
   end

   assign step       = kvt_pkg::kvt_step(doc_ff, hold_byte_ff, hold_eod_ff, lim);
   assign group      = step.grp;
   assign group_load = hold_valid_ff && sink_free;
   assign req.ready  = !hold_valid_ff || sink_free;
   assign take_req   = req.valid && req.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      hold_eod_in   = hold_eod_ff;
      doc_in        = doc_ff;
      if (req.ready) begin
         hold_valid_in = req.valid;
      end
      if (take_req) begin
         hold_byte_in = req.data_byte;
         hold_eod_in  = req.end_of_document;
      end
      if (group_load) begin
         doc_in = step.doc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         doc_ff        <= kvt_pkg::DOC_CLEAR;
      end else begin
         hold_valid_ff <= hold_valid_in;
         doc_ff        <= doc_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      hold_eod_ff  <= hold_eod_in;
   end

endmodule

[rtl/kvt_out_queue.sv]
`timescale 1ns / 1ps
// Result register holding one event group, drained one word per cycle while rsp.ready is high.
// Depends on kvt_pkg (group and event types) and kvt_rsp_if.
module kvt_out_queue (
   input  logic               clock,
   input  logic               reset,
   input  kvt_pkg::group_type group,
   input  logic               group_load,
   output logic               sink_free,
   kvt_rsp_if.source          rsp
);

   kvt_pkg::event_type [kvt_pkg::MAX_EVENTS-1:0] ev_ff, ev_in;
   logic [2:0]         left_ff, left_in;
   logic [1:0]         index_ff, index_in;
   kvt_pkg::event_type head;
   logic               take;

   assign head      = ev_ff[index_ff];
   assign take      = rsp.valid && rsp.ready;
   assign sink_free = (left_ff == 3'd0) || ((left_ff == 3'd1) && rsp.ready);

   assign rsp.valid       = left_ff != 3'd0;
   assign rsp.event_kind  = head.event_kind;
   assign rsp.char_out    = head.char_out;
   assign rsp.nest_depth  = head.nest_depth;
   assign rsp.error_code  = head.error_code;
   assign rsp.last_of_run = left_ff == 3'd1;

   always_comb begin
      ev_in    = ev_ff;
      left_in  = left_ff;
      index_in = index_ff;
      priority if (group_load) begin
         ev_in    = group.ev;
         left_in  = group.count;
         index_in = 2'd0;
      end else if (take) begin
         left_in  = left_ff - 3'd1;
         index_in = index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= 3'd0;
         index_ff <= 2'd0;
      end else begin
         left_ff  <= left_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff <= ev_in;
   end

endmodule

[rtl/keyvalue_text_tokenizer.sv]
`timescale 1ns / 1ps
// Top level of the key/value text tokenizer: register file, lexer and result queue.
// Depends on kvt_pkg, kvt_req_if, kvt_rsp_if, kvt_csr, kvt_lexer and kvt_out_queue.
//
//   channel   direction  handshake               word
//   req_chan  in         valid/ready             data_byte, end_of_document
//   rsp_chan  out        valid/ready             event_kind .. last_of_run
//   APB       in/out     psel/penable, pready=1  4 limit registers at 4*i
//
// One byte per cycle while each byte gives at most one event and rsp_chan.ready is high;
// a byte that gives more events holds the next byte while the result queue drains.
// The first event of a byte passes the input register, then the result register, before it leaves.
// Synchronous reset clears document state and restores the limit defaults at once.
// rsp_chan.ready low stalls the result queue and drops req_chan.ready in the same
// cycle while a word is held; an empty input register still takes one more word.
module keyvalue_text_tokenizer #(
   parameter int unsigned DEPTH_LIMIT_MAX = 63,
   parameter int unsigned TOKEN_LIMIT_MAX = 8191,
   parameter int unsigned ENTRY_LIMIT_MAX = 131071
) (
   input  logic                           clock,
   input  logic                           reset,
   kvt_req_if.sink                        req_chan,
   kvt_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [kvt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   kvt_pkg::limit_type limits;
   kvt_pkg::group_type group;
   logic               group_load;
   logic               sink_free;

   kvt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limits  (limits)
   );

   kvt_lexer #(
      .DEPTH_LIMIT_MAX (DEPTH_LIMIT_MAX),
      .TOKEN_LIMIT_MAX (TOKEN_LIMIT_MAX),
      .ENTRY_LIMIT_MAX (ENTRY_LIMIT_MAX)
   ) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .limits     (limits),
      .sink_free  (sink_free),
      .group      (group),
      .group_load (group_load)
   );

   kvt_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .group      (group),
      .group_load (group_load),
      .sink_free  (sink_free),
      .rsp        (rsp_chan)
   );

   a_group_shows: assert property (@(posedge clock) disable iff (reset)
      (group_load && (group.count != 3'd0)) |=> rsp_chan.valid)
      else $error("loaded event group not presented");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         ((rsp_chan.event_kind == kvt_pkg::EV_ERROR) ==
          (rsp_chan.error_code != kvt_pkg::ERR_NONE)))
      else $error("error code does not match event kind");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.event_kind != kvt_pkg::EV_KEY_CHAR)
                      && (rsp_chan.event_kind != kvt_pkg::EV_VALUE_CHAR))
         |-> (rsp_chan.char_out == 8'h00))
      else $error("character on a non-character event");

endmodule
